>>> rtl/tlbdp_pkg.sv
`timescale 1ns / 1ps

package tlbdp_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 256;

    localparam int VA_W        = 16;
    localparam int VPN_W       = 8;
    localparam int OFFSET_W    = 8;
    localparam int PA_W        = 16;
    localparam int PFN_OUT_W   = 8;
    localparam int FAULT_TOT_W = 9;
    localparam int HIT_TOT_W   = 32;

    localparam int S_TDATA_W   = 16;
    localparam int M_FIELDS_W  = PA_W + 1 + 1 + FAULT_TOT_W + HIT_TOT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

endpackage

>>> rtl/tlb_demand_paging_translator.sv
`timescale 1ns / 1ps

// Translates 16-bit virtual addresses (page in bits 15:8, offset in 7:0) through a
// fully associative TLB with FIFO replacement, backed by a page table that hands out
// free frames in order on first touch (page fault). One result word per address,
// carrying the physical address, hit and fault flags and the running fault and hit
// totals. Addresses do not overlap: the accept cycle launches the page table RAM read
// (registered read port), the next cycle matches the TLB tags, resolves and writes back
// the page table, TLB and counters. The result sits in an output register; a stalled
// m_axis_tready holds S_LOOK until the register frees up. After reset the page table
// RAM is swept clear, one entry a cycle, before the first address is taken.
module tlb_demand_paging_translator
    import tlbdp_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] vaddr

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] paddr, [16] tlb_hit, [17] page_fault,
    // [26:18] fault_total, [58:27] hit_total, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CW    = $clog2(FRAME_COUNT + 1);
    localparam int PTR_W = $clog2(TLB_ENTRIES);
    localparam int VPN_N = 1 << VPN_W;

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [OFFSET_W-1:0]  r_va;
    logic [PW-1:0]        r_page;
    logic [PW-1:0]        r_clr_addr;

    logic                 r_tlb_valid [TLB_ENTRIES];
    logic [PW-1:0]        r_tlb_tag   [TLB_ENTRIES];
    logic [FW-1:0]        r_tlb_frame [TLB_ENTRIES];
    logic [PTR_W-1:0]     r_tlb_ptr;

    logic [CW-1:0]        r_next_free;
    logic [HIT_TOT_W-1:0] r_hit_cnt;

    // page table RAM word: {mapped, frame}
    logic [FW:0]          r_pt_mem [PAGE_COUNT];
    logic [FW:0]          r_pt_rdata;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // ---------------- page index: vpn modulo PAGE_COUNT via constant table ----------------
    logic [PW-1:0] w_page_lut [VPN_N];
    for (genvar g = 0; g < VPN_N; g++) begin : g_page_lut
        assign w_page_lut[g] = PW'(g % PAGE_COUNT);
    end

    logic [PW-1:0] w_in_page;
    assign w_in_page = w_page_lut[s_axis_tdata[VA_W-1 -: VPN_W]];

    // ---------------- control ----------------
    logic w_accept;
    logic w_done;
    logic w_clr_last;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_clr_last = (r_clr_addr == PW'(PAGE_COUNT - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (w_clr_last) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) n_state = S_LOOK;
            S_LOOK:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_done        = 1'b0;
        unique case (r_state)
            S_CLEAR: ;
            S_IDLE:  s_axis_tready = 1'b1;
            S_LOOK:  w_done = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va   <= s_axis_tdata[OFFSET_W-1:0];
            r_page <= w_in_page;
        end
    end

    // ---------------- TLB lookup ----------------
    logic [TLB_ENTRIES-1:0] w_match;
    logic [FW-1:0]          w_hit_frame;
    logic                   w_hit;

    always_comb begin
        w_hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            w_match[i]  = r_tlb_valid[i] && (r_tlb_tag[i] == r_page);
            w_hit_frame = w_hit_frame | ({FW{w_match[i]}} & r_tlb_frame[i]);
        end
    end
    assign w_hit = |w_match;

    // ---------------- resolve ----------------
    logic                 w_pt_mapped;
    logic [FW-1:0]        w_pt_frame;
    logic                 w_fault;
    logic                 w_have;
    logic [FW-1:0]        w_frame;
    logic [CW-1:0]        n_next_free;
    logic [HIT_TOT_W-1:0] n_hit_cnt;

    assign w_pt_mapped = r_pt_rdata[FW];
    assign w_pt_frame  = r_pt_rdata[FW-1:0];

    always_comb begin
        w_fault     = 1'b0;
        w_have      = 1'b0;
        w_frame     = '0;
        n_next_free = r_next_free;
        n_hit_cnt   = r_hit_cnt;
        if (w_hit) begin
            w_frame = w_hit_frame;
            if (r_hit_cnt != '1) n_hit_cnt = r_hit_cnt + 1'b1;
        end else if (w_pt_mapped) begin
            w_frame = w_pt_frame;
            w_have  = 1'b1;
        end else if (r_next_free < CW'(FRAME_COUNT)) begin
            w_frame     = FW'(r_next_free);
            w_fault     = 1'b1;
            w_have      = 1'b1;
            n_next_free = r_next_free + 1'b1;
        end
    end

    // ---------------- page table RAM ----------------
    logic          w_pt_we;
    logic [PW-1:0] w_pt_waddr;
    logic [FW:0]   w_pt_wdata;

    assign w_pt_we    = (r_state == S_CLEAR) || (w_done && w_fault);
    assign w_pt_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_page;
    assign w_pt_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, w_frame};

    // read at accept, write back when the lookup completes; items never overlap so no bypass
    always_ff @(posedge i_clk) begin
        if (w_pt_we) r_pt_mem[w_pt_waddr] <= w_pt_wdata;
        if (w_accept) r_pt_rdata <= r_pt_mem[w_in_page];
    end

    // ---------------- TLB and counters update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++) r_tlb_valid[i] <= 1'b0;
            r_tlb_ptr   <= '0;
            r_next_free <= '0;
            r_hit_cnt   <= '0;
        end else if (w_done) begin
            r_next_free <= n_next_free;
            r_hit_cnt   <= n_hit_cnt;
            if (w_have) begin
                r_tlb_valid[r_tlb_ptr] <= 1'b1;
                r_tlb_ptr <= (r_tlb_ptr == PTR_W'(TLB_ENTRIES - 1)) ? '0
                                                                   : r_tlb_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_have) begin
            r_tlb_tag[r_tlb_ptr]   <= r_page;
            r_tlb_frame[r_tlb_ptr] <= w_frame;
        end
    end

    // ---------------- output register ----------------
    logic [M_FIELDS_W-1:0] w_fields;
    assign w_fields = {n_hit_cnt, FAULT_TOT_W'(n_next_free), w_fault, w_hit,
                       PFN_OUT_W'(w_frame), r_va[OFFSET_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_out_data <= M_TDATA_W'(w_fields);
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("input taken during page table clear");

    a_hit_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[PA_W] && r_out_data[PA_W+1]))
        else $error("result flagged as both TLB hit and page fault");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CW'(FRAME_COUNT))
        else $error("frame allocation beyond frame count");

    a_result_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOOK))
        else $error("result word without a lookup");

    a_tlb_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> $onehot0(w_match))
        else $error("page held in more than one TLB entry");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlbdp_pkg::*;

    typedef struct {
        logic [PA_W-1:0]        pa;
        logic                   hit;
        logic                   fault;
        logic [FAULT_TOT_W-1:0] ftot;
        logic [HIT_TOT_W-1:0]   htot;
    } t_xlat;

    localparam int RAND_WORDS = 1150;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [15:0] vaddr
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] paddr, [16] tlb_hit, [17] page_fault,
    // [26:18] fault_total, [58:27] hit_total, rest zero
    logic [M_TDATA_W-1:0] m_axis_tdata;

    tlb_demand_paging_translator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // translator model state
    bit          tlb_valid_q [TLB_ENTRIES_DEF];
    int unsigned tlb_tag_q   [TLB_ENTRIES_DEF];
    int unsigned tlb_frame_q [TLB_ENTRIES_DEF];
    int unsigned tlb_ptr;
    bit          page_mapped_q [PAGE_COUNT_DEF];
    int unsigned page_frame_q  [PAGE_COUNT_DEF];
    int unsigned next_frame;
    logic [HIT_TOT_W-1:0] hit_tally = '0;

    t_xlat pending_xlat[$];
    int    errors = 0;
    int    words_sent = 0;
    logic  hold_off = 1'b0;
    int    ready_wait = 0;
    int    rx_cycle = 0;

    // directed rows
    logic [VA_W-1:0] dir_va[$];
    bit              dir_typed[$];
    t_xlat           dir_want[$];

    function automatic t_xlat translate(input logic [VA_W-1:0] va);
        int unsigned page;
        int unsigned ofs;
        int unsigned frame;
        int unsigned slot;
        bit found;
        bit have;
        t_xlat r;
        page  = int'(va[VA_W-1:OFFSET_W]) % PAGE_COUNT_DEF;
        ofs   = int'(va[OFFSET_W-1:0]);
        frame = 0;
        found = 0;
        have  = 0;
        r.hit   = 1'b0;
        r.fault = 1'b0;
        for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
            if (!found && tlb_valid_q[i] && tlb_tag_q[i] == page) begin
                found = 1;
                frame = tlb_frame_q[i];
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (hit_tally != '1)
                hit_tally = hit_tally + 1;
        end else begin
            if (page_mapped_q[page]) begin
                frame = page_frame_q[page];
                have  = 1;
            end else if (next_frame < FRAME_COUNT_DEF) begin
                // first touch: hand out the next frame
                frame = next_frame;
                page_frame_q[page]  = frame;
                page_mapped_q[page] = 1;
                next_frame = next_frame + 1;
                r.fault = 1'b1;
                have = 1;
            end
            if (have) begin
                slot = tlb_ptr % TLB_ENTRIES_DEF;
                tlb_valid_q[slot] = 1;
                tlb_tag_q[slot]   = page;
                tlb_frame_q[slot] = frame;
                tlb_ptr = (slot + 1) % TLB_ENTRIES_DEF;
            end
        end
        r.pa   = PA_W'((frame << OFFSET_W) + ofs);
        r.ftot = FAULT_TOT_W'(next_frame);
        r.htot = hit_tally;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    task automatic add_row(input logic [VA_W-1:0] va, input bit typed,
                           input logic [PA_W-1:0] pa, input logic hit, input logic fault,
                           input int ftot, input int htot);
        t_xlat w;
        w.pa    = pa;
        w.hit   = hit;
        w.fault = fault;
        w.ftot  = FAULT_TOT_W'(ftot);
        w.htot  = HIT_TOT_W'(htot);
        dir_va.push_back(va);
        dir_typed.push_back(typed);
        dir_want.push_back(w);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
        errors++;
    endtask

    task automatic check_word(input logic [M_TDATA_W-1:0] w);
        t_xlat e;
        if (pending_xlat.size() == 0) begin
            report_mismatch("unexpected word", w, 0);
        end else begin
            e = pending_xlat.pop_front();
            if (w[15:0] !== e.pa)
                report_mismatch("paddr", w[15:0], e.pa);
            if (w[16] !== e.hit)
                report_mismatch("tlb_hit", w[16], e.hit);
            if (w[17] !== e.fault)
                report_mismatch("page_fault", w[17], e.fault);
            if (w[26:18] !== e.ftot)
                report_mismatch("fault_total", w[26:18], e.ftot);
            if (w[58:27] !== e.htot)
                report_mismatch("hit_total", w[58:27], e.htot);
            if (w[M_TDATA_W-1:59] !== '0)
                report_mismatch("padding", w[M_TDATA_W-1:59], 0);
        end
    endtask

    // offers one word and holds it until taken; prediction follows acceptance order
    task automatic send_word(input logic [VA_W-1:0] va, input bit typed, input t_xlat want);
        t_xlat p;
        s_axis_tdata  <= va;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        p = translate(va);
        pending_xlat.push_back(typed ? want : p);
        words_sent++;
    endtask

    task automatic sender_gap();
        int g;
        g = ((words_sent / 64) % 4 == 1) ? 0 : pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus
    initial begin
        logic [7:0] ws[8];
        int         ws_ptr;
        int         sweep;
        int         r;
        logic [7:0] page;
        t_xlat      none;

        none = '{default: '0};
        ws_ptr = 0;
        sweep  = 0;
        for (int i = 0; i < 8; i++)
            ws[i] = 8'($urandom_range(0, 255));

        // fresh after reset: first touches, then hits on the same pages
        add_row(16'h0000, 1, 16'h0000, 1'b0, 1'b1, 1, 0);
        add_row(16'hFFFF, 1, 16'h01FF, 1'b0, 1'b1, 2, 0);
        add_row(16'h00FF, 1, 16'h00FF, 1'b1, 1'b0, 2, 1);
        add_row(16'hFF00, 1, 16'h0100, 1'b1, 1'b0, 2, 2);
        // fill the rest of the TLB
        for (int p = 1; p <= 14; p++)
            add_row({8'(p), (p % 2) ? 8'hA5 : 8'h5A}, 0, 0, 0, 0, 0, 0);
        // FIFO wraps: evicts page 0, then page 0 reloads from the page table
        add_row(16'h8033, 0, 0, 0, 0, 0, 0);
        add_row(16'h0042, 1, 16'h0042, 1'b0, 1'b0, 17, 2);
        add_row(16'h0042, 1, 16'h0042, 1'b1, 1'b0, 17, 3);
        add_row(16'hFF80, 1, 16'h0180, 1'b0, 1'b0, 17, 3);
        add_row(16'h0E7F, 0, 0, 0, 0, 0, 0);

        while (!i_rst_n) @(posedge i_clk);

        for (int i = 0; i < dir_va.size(); i++) begin
            send_word(dir_va[i], dir_typed[i], dir_want[i]);
            sender_gap();
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                // walk every page so all frames get handed out
                page = 8'(sweep);
                sweep = (sweep + 1) % 256;
            end else if (r < 70) begin
                page = ws[$urandom_range(0, 7)];
            end else begin
                page = 8'($urandom_range(0, 255));
                ws[ws_ptr] = page;
                ws_ptr = (ws_ptr + 1) % 8;
            end
            send_word({page, 8'($urandom_range(0, 255))}, 0, none);
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_xlat.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // long receiver hold-off so the pipe backs up into the input
    initial begin
        while (words_sent < HOLD_AT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (m_axis_tvalid && m_axis_tready)
            check_word(m_axis_tdata);
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (ready_wait > 0) begin
            ready_wait    <= ready_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            // quiet stretch: no stalls
            if ((rx_cycle / 500) % 5 != 2 && $urandom_range(0, 3) == 0)
                ready_wait <= pick_gap();
        end
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
